@@ hdl/crank_angle_decoder_24x_defines.svh @@
// ----------------------------------------------------------------------------
// Crank angle decoder assertion macros
// Shared property forms for the decoder's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef CRANK_ANGLE_DECODER_24X_DEFINES_SVH
`define CRANK_ANGLE_DECODER_24X_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CAD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("decoder check failed (same cycle)");

// next-cycle implication, disabled during reset
`define CAD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("decoder check failed (next cycle)");

`endif

@@ hdl/cad_pkg.sv @@
// ----------------------------------------------------------------------------
// cad_pkg
// Types, constants and the base angle table of the crank angle decoder.
// ----------------------------------------------------------------------------
package cad_pkg;

  localparam int WIN_N  = 12;   // ring entries in the match window: the matched edge and those before it
  localparam int DIV_DW = 54;   // divider dividend / quotient width
  localparam int POS_W  = 53;   // unwrapped position width

  localparam logic [24:0] FULL_TURN_Q16 = 25'd23592960;  // 360 in Q9.16
  localparam logic [31:0] HALF_RANGE    = 32'h80000000;

  localparam logic [1:0] DIV_POS  = 2'd0;
  localparam logic [1:0] DIV_WRAP = 2'd1;
  localparam logic [1:0] DIV_RATE = 2'd2;

  localparam logic [2:0] REG_TPS_IDX = 3'd0;
  localparam logic [31:0] TPS_RESET  = 32'd1000000;

  typedef struct packed {
    logic       ok;
    logic [8:0] angle;
    logic [3:0] pulse;
  } angle_t;

  typedef struct packed {
    logic       wr_edge;
    logic       load_q;
    logic       rd_prev;
    logic       walk_back;
    logic       rd_fetch;
    logic [3:0] fetch_idx;
    logic       st_win;
    logic [3:0] win_idx;
    logic       calc_d;
    logic       pulse_step;
    logic [2:0] pulse_k;
    logic       lookup;
    logic       div_start;
    logic       wrap_start;
    logic       div_take;
    logic [1:0] div_sel;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic newest_valid;
    logic walk_more;
    logic prev_bad;
    logic v8_bad;
    logic stall_bad;
    logic sim_bad;
    logic angle_bad;
    logic period_zero;
    logic need_wrap;
    logic div_done;
    logic wrap_done;
  } sts_t;

  // pattern bit 4 = newest pulse long, bit 0 = oldest
  function automatic angle_t base_angle(input logic [4:0] pat, input logic lvl);
    logic [8:0] a0;
    logic [8:0] a1;
    logic       ok;
    angle_t     r;
    ok = 1'b1;
    case (pat)
      5'd0:  begin a0 = 9'd15;  a1 = 9'd18;  end
      5'd1:  begin a0 = 9'd0;   a1 = 9'd12;  end
      5'd2:  begin a0 = 9'd345; a1 = 9'd357; end
      5'd3:  begin a0 = 9'd255; a1 = 9'd258; end
      5'd5:  begin a0 = 9'd330; a1 = 9'd342; end
      5'd6:  begin a0 = 9'd240; a1 = 9'd252; end
      5'd7:  begin a0 = 9'd180; a1 = 9'd183; end
      5'd8:  begin a0 = 9'd285; a1 = 9'd288; end
      5'd10: begin a0 = 9'd315; a1 = 9'd327; end
      5'd12: begin a0 = 9'd225; a1 = 9'd237; end
      5'd14: begin a0 = 9'd165; a1 = 9'd177; end
      5'd15: begin a0 = 9'd105; a1 = 9'd108; end
      5'd16: begin a0 = 9'd30;  a1 = 9'd33;  end
      5'd17: begin a0 = 9'd270; a1 = 9'd282; end
      5'd19: begin a0 = 9'd195; a1 = 9'd198; end
      5'd20: begin a0 = 9'd300; a1 = 9'd312; end
      5'd23: begin a0 = 9'd120; a1 = 9'd123; end
      5'd24: begin a0 = 9'd45;  a1 = 9'd48;  end
      5'd25: begin a0 = 9'd210; a1 = 9'd222; end
      5'd27: begin a0 = 9'd135; a1 = 9'd138; end
      5'd28: begin a0 = 9'd60;  a1 = 9'd63;  end
      5'd29: begin a0 = 9'd150; a1 = 9'd162; end
      5'd30: begin a0 = 9'd75;  a1 = 9'd78;  end
      5'd31: begin a0 = 9'd90;  a1 = 9'd102; end
      default: begin
        ok = 1'b0;
        a0 = '0;
        a1 = '0;
      end
    endcase
    r.ok    = ok;
    r.angle = lvl ? a1 : a0;
    // high-level angles sit 3 or 12 past their low-level mate: that is the pulse
    r.pulse = lvl ? 4'(a1 - a0) : (pat[4] ? 4'd12 : 4'd3);
    return r;
  endfunction

endpackage

@@ hdl/cad_ram.sv @@
// ----------------------------------------------------------------------------
// cad_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cad_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/cad_div.sv @@
// ----------------------------------------------------------------------------
// cad_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cad_div #(
  parameter int DW = 54,
  parameter int VW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quot
);

  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [VW-1:0] dv;
  logic [VW-1:0] rem;
  logic [VW:0]   trial;
  logic          fits;

  assign trial = {rem, quot[DW-1]};
  assign fits  = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dv   <= divisor;
    end else if (busy) begin
      quot <= {quot[DW-2:0], fits};
      rem  <= fits ? VW'(trial - {1'b0, dv}) : trial[VW-1:0];
    end
  end

endmodule

@@ hdl/cad_dp.sv @@
// ----------------------------------------------------------------------------
// cad_dp
// Decoder datapath: edge ring, match window, pulse classification,
// interpolation and rate arithmetic, result registers.
// ----------------------------------------------------------------------------
module cad_dp import cad_pkg::*; #(
  parameter int RING_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] edge_tick,
  input  logic        edge_level,
  input  logic [31:0] query_tick,
  input  logic [31:0] now_tick,
  input  logic [31:0] tps,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic        synced,
  output logic [24:0] position,
  output logic [31:0] angular_rate,
  output logic [31:0] calculated_tick
);

  localparam int IW = $clog2(RING_DEPTH);
  localparam logic [IW:0] DEPTH_EXT = (IW + 1)'(RING_DEPTH);

  function automatic logic [IW-1:0] back_idx(input logic [IW-1:0] i, input logic [3:0] n);
    logic [IW:0] s;
    if ({1'b0, i} >= (IW + 1)'(n)) begin
      s = {1'b0, i} - (IW + 1)'(n);
    end else begin
      s = {1'b0, i} + DEPTH_EXT - (IW + 1)'(n);
    end
    return s[IW-1:0];
  endfunction

  function automatic logic [12:0] csub(input logic [12:0] x, input logic [12:0] c);
    return (x >= c) ? x - c : x;
  endfunction

  logic [IW-1:0]         newest;
  logic [IW-1:0]         next_slot;
  logic [RING_DEPTH-1:0] vld;
  logic [IW-1:0]         last;
  logic [IW-1:0]         start;
  logic [IW-1:0]         prev_idx;
  logic [IW-1:0]         raddr;
  logic [32:0]           rdata;
  logic                  rd_vld;
  logic [31:0]           rtick;
  logic                  rlvl;

  logic [31:0] q;
  logic [31:0] now;
  logic [31:0] w_tick [WIN_N];
  logic        w_lvl  [WIN_N];
  logic [31:0] d1;
  logic [31:0] d2;
  logic [31:0] d3;
  logic [4:0]  pat;
  logic [8:0]  angle_r;
  logic [3:0]  pulse_r;
  logic        ang_ok;
  logic [31:0] period_r;
  logic [31:0] elapsed_r;
  logic [POS_W-1:0] pos_r;
  logic [31:0] rate_r;
  logic        ok_r;

  logic [3:0]  pb;
  logic [3:0]  pf;
  logic [31:0] p_high;
  logic [31:0] p_period;
  logic        p_long;
  logic [3:0]  doff;
  angle_t      ang;

  logic [35:0]       mul_pos;
  logic [35:0]       mul_rate;
  logic [DIV_DW-1:0] div_dividend;
  logic [31:0]       div_divisor;
  logic              div_done;
  logic [DIV_DW-1:0] div_quot;

  logic [POS_W-1:0] wv;
  logic [18:0]      wr_lo;
  logic [13:0]      wr_s1;
  logic [12:0]      wr_s2;
  logic [12:0]      wr_s3;
  logic [5:0]       wr_m;
  logic [3:0]       wr_vld;

  // ---------------- ring ----------------
  assign next_slot = (newest == IW'(RING_DEPTH - 1)) ? '0 : newest + 1'b1;
  assign prev_idx  = back_idx(last, 4'd1);

  always_comb begin
    if (cmd.rd_fetch) begin
      raddr = back_idx(last, cmd.fetch_idx);
    end else if (cmd.rd_prev) begin
      raddr = prev_idx;
    end else begin
      raddr = last;
    end
  end

  cad_ram #(.WIDTH(33), .DEPTH(RING_DEPTH)) u_ring (
    .clk   (clk),
    .we    (cmd.wr_edge),
    .waddr (next_slot),
    .wdata ({edge_level, edge_tick}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // entries never written read as zero
  assign rtick = rd_vld ? rdata[31:0] : '0;
  assign rlvl  = rd_vld & rdata[32];

  always_ff @(posedge clk) begin
    if (rst) begin
      newest <= IW'(RING_DEPTH - 1);
      vld    <= '0;
    end else if (cmd.wr_edge) begin
      newest          <= next_slot;
      vld[next_slot]  <= 1'b1;
    end
  end

  // ---------------- pulse classification mux ----------------
  assign pb       = {cmd.pulse_k, 1'b0};
  assign pf       = pb + {3'd0, w_lvl[pb]};
  assign p_high   = w_tick[pf] - w_tick[pf + 4'd1];
  assign p_period = w_tick[pf] - w_tick[pf + 4'd2];
  assign p_long   = p_high > {1'b0, p_period[31:1]};

  assign doff = {3'd0, w_lvl[0]};
  assign ang  = base_angle(pat, w_lvl[0]);

  // ---------------- divider operands ----------------
  assign mul_pos  = 36'(elapsed_r) * 36'(pulse_r);
  assign mul_rate = 36'(tps) * 36'(pulse_r);

  always_comb begin
    case (cmd.div_sel)
      DIV_POS: begin
        div_dividend = DIV_DW'({mul_pos, 16'd0});
        div_divisor  = period_r;
      end
      default: begin
        div_dividend = DIV_DW'({mul_rate, 8'd0});
        div_divisor  = period_r;
      end
    endcase
  end

  cad_div #(.DW(DIV_DW), .VW(32)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot)
  );

  // ---------------- wrap: (pos - 1) mod 45*2^19 ----------------
  // low 19 bits pass; the high part is reduced mod 45 using 2^12 = 1 (mod 45)
  assign wv = pos_r - POS_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_vld <= '0;
    end else begin
      wr_vld <= {wr_vld[2:0], cmd.wrap_start};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wrap_start) begin
      wr_lo <= wv[18:0];
      wr_s1 <= 14'(wv[30:19]) + 14'(wv[42:31]) + 14'(wv[52:43]);
    end
    wr_s2 <= 13'(wr_s1[11:0]) + 13'(wr_s1[13:12]);
    // 45 times 64, 32, 16, 8, then 4, 2, 1
    wr_s3 <= csub(csub(csub(csub(wr_s2, 13'd2880), 13'd1440), 13'd720), 13'd360);
    wr_m  <= 6'(csub(csub(csub(wr_s3, 13'd180), 13'd90), 13'd45));
  end

  // ---------------- working registers ----------------
  always_ff @(posedge clk) begin
    rd_vld <= vld[raddr];
    if (cmd.load_q) begin
      q     <= query_tick;
      now   <= now_tick;
      last  <= newest;
      start <= newest;
      ok_r  <= 1'b0;
    end
    if (cmd.walk_back) begin
      last <= prev_idx;
    end
    if (cmd.st_win) begin
      w_tick[cmd.win_idx] <= rtick;
      w_lvl[cmd.win_idx]  <= rlvl;
    end
    if (cmd.calc_d) begin
      d1 <= now - w_tick[doff];
      d2 <= w_tick[0] - w_tick[doff + 4'd2];
      d3 <= w_tick[doff + 4'd2] - w_tick[doff + 4'd4];
    end
    if (cmd.pulse_step) begin
      pat <= {pat[3:0], p_long};
    end
    if (cmd.lookup) begin
      angle_r   <= ang.angle;
      pulse_r   <= ang.pulse;
      ang_ok    <= ang.ok;
      period_r  <= w_tick[0] - w_tick[1];
      elapsed_r <= q - w_tick[0];
    end
    if (cmd.div_take) begin
      case (cmd.div_sel)
        DIV_POS:  pos_r <= POS_W'({angle_r, 16'd0}) + div_quot[POS_W-1:0];
        DIV_WRAP: pos_r <= POS_W'({wr_m, wr_lo}) + POS_W'(1);
        default: begin
          rate_r <= (|div_quot[DIV_DW-1:32]) ? '1 : div_quot[31:0];
          ok_r   <= 1'b1;
        end
      endcase
    end
    if (cmd.load_out) begin
      synced          <= ok_r;
      position        <= ok_r ? pos_r[24:0] : '0;
      angular_rate    <= ok_r ? rate_r : '0;
      calculated_tick <= q;
    end
  end

  // ---------------- status ----------------
  always_comb begin
    sts.newest_valid = vld[last];
    sts.walk_more    = (q - rtick) > HALF_RANGE;
    sts.prev_bad     = !vld[prev_idx] || (prev_idx == start);
    sts.v8_bad       = !vld[back_idx(last, 4'd8)];
    sts.stall_bad    = {1'b0, d1} > {d2, 1'b0};
    sts.sim_bad      = ({d2, 1'b0} < {1'b0, d3}) || ({1'b0, d2} > {d3, 1'b0});
    sts.angle_bad    = !ang_ok;
    sts.period_zero  = period_r == '0;
    sts.need_wrap    = pos_r > POS_W'(FULL_TURN_Q16);
    sts.div_done     = div_done;
    sts.wrap_done    = wr_vld[3];
  end

endmodule

@@ hdl/cad_ctrl.sv @@
// ----------------------------------------------------------------------------
// cad_ctrl
// Decoder sequencer: input/output handshakes and the query step order.
// ----------------------------------------------------------------------------
module cad_ctrl import cad_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic opcode,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHK   = 4'd1;
  localparam logic [3:0] S_WCMP  = 4'd2;
  localparam logic [3:0] S_FETCH = 4'd3;
  localparam logic [3:0] S_DIFF  = 4'd4;
  localparam logic [3:0] S_SIM   = 4'd5;
  localparam logic [3:0] S_PULSE = 4'd6;
  localparam logic [3:0] S_ANGLE = 4'd7;
  localparam logic [3:0] S_MUL   = 4'd8;
  localparam logic [3:0] S_DPOS  = 4'd9;
  localparam logic [3:0] S_WRAP  = 4'd10;
  localparam logic [3:0] S_DWRAP = 4'd11;
  localparam logic [3:0] S_RATE  = 4'd12;
  localparam logic [3:0] S_DRATE = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [3:0] fc;
  logic [3:0] fc_next;
  logic [2:0] pk;
  logic [2:0] pk_next;
  logic       out_valid_next;
  logic       accept;

  assign in_stall = state != S_IDLE;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    fc_next        = fc;
    pk_next        = pk;
    cmd.wr_edge    = accept && !opcode;
    cmd.load_q     = accept && opcode;
    cmd.fetch_idx  = fc;
    cmd.win_idx    = fc - 4'd1;
    cmd.pulse_k    = pk;
    case (state)
      S_IDLE: begin
        if (cmd.load_q) begin
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        state_next = sts.newest_valid ? S_WCMP : S_DONE;
      end
      S_WCMP: begin
        if (sts.walk_more) begin
          if (sts.prev_bad) begin
            state_next = S_DONE;
          end else begin
            cmd.walk_back = 1'b1;
            cmd.rd_prev   = 1'b1;
          end
        end else if (sts.v8_bad) begin
          state_next = S_DONE;
        end else begin
          fc_next    = '0;
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        // reads run one ahead of the window writes
        cmd.rd_fetch = fc < 4'(WIN_N);
        cmd.st_win   = fc != 4'd0;
        fc_next      = fc + 4'd1;
        if (fc == 4'(WIN_N)) begin
          state_next = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.calc_d = 1'b1;
        state_next = S_SIM;
      end
      S_SIM: begin
        pk_next    = '0;
        state_next = (sts.stall_bad || sts.sim_bad) ? S_DONE : S_PULSE;
      end
      S_PULSE: begin
        cmd.pulse_step = 1'b1;
        pk_next        = pk + 3'd1;
        if (pk == 3'd4) begin
          state_next = S_ANGLE;
        end
      end
      S_ANGLE: begin
        cmd.lookup = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        if (sts.angle_bad || sts.period_zero) begin
          state_next = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_POS;
          state_next    = S_DPOS;
        end
      end
      S_DPOS: begin
        cmd.div_sel = DIV_POS;
        if (sts.div_done) begin
          cmd.div_take = 1'b1;
          state_next   = S_WRAP;
        end
      end
      S_WRAP: begin
        if (sts.need_wrap) begin
          cmd.wrap_start = 1'b1;
          state_next     = S_DWRAP;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_RATE;
          state_next    = S_DRATE;
        end
      end
      S_DWRAP: begin
        cmd.div_sel = DIV_WRAP;
        if (sts.wrap_done) begin
          cmd.div_take = 1'b1;
          state_next   = S_RATE;
        end
      end
      S_RATE: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_RATE;
        state_next    = S_DRATE;
      end
      S_DRATE: begin
        cmd.div_sel = DIV_RATE;
        if (sts.div_done) begin
          cmd.div_take = 1'b1;
          state_next   = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fc        <= '0;
      pk        <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fc        <= fc_next;
      pk        <= pk_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ hdl/crank_angle_decoder_24x.sv @@
// ----------------------------------------------------------------------------
// crank_angle_decoder_24x
// 24x trigger wheel decoder: edge ring, crank angle and angular rate.
// ----------------------------------------------------------------------------
// An edge transaction (opcode 0) is stored and gives no result; the block
// is ready again the next cycle. A query transaction (opcode 1) gives one
// result; it runs longer when the angle wraps past 360 degrees and the more
// ring entries are walked back to reach the edge at or before the query
// tick. A query that is rejected early (no history, stalled or irregular
// wheel, bad pattern) goes straight to its result. The single
// one-bit-per-cycle divider is shared by interpolation and rate, and the
// ring memory gives one read per cycle. A finished result waits in the
// output register while edges keep coming in.
// ----------------------------------------------------------------------------
`include "crank_angle_decoder_24x_defines.svh"

module crank_angle_decoder_24x import cad_pkg::*; #(
  parameter int RING_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [31:0] edge_tick,
  input  logic        edge_level,
  input  logic [31:0] query_tick,
  input  logic [31:0] now_tick,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        synced,
  output logic [24:0] position,
  output logic [31:0] angular_rate,
  output logic [31:0] calculated_tick,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] tps;
  logic        reg_hit;
  cmd_t        cmd;
  sts_t        sts;

  assign pready  = 1'b1;
  assign reg_hit = {paddr[2], 2'b00} == REG_TPS_IDX;
  assign prdata  = reg_hit ? tps : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tps <= TPS_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      tps <= pwdata;
    end
  end

  cad_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .opcode    (opcode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  cad_dp #(.RING_DEPTH(RING_DEPTH)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .edge_tick       (edge_tick),
    .edge_level      (edge_level),
    .query_tick      (query_tick),
    .now_tick        (now_tick),
    .tps             (tps),
    .cmd             (cmd),
    .sts             (sts),
    .synced          (synced),
    .position        (position),
    .angular_rate    (angular_rate),
    .calculated_tick (calculated_tick)
  );

  `CAD_ASSERT_NEXT(a_query_busy, in_valid && !in_stall && opcode, in_stall)
  `CAD_ASSERT_NEXT(a_edge_ready, in_valid && !in_stall && !opcode, !in_stall)
  `CAD_ASSERT_SAME(a_load_free, cmd.load_out, !out_valid || !out_stall)

endmodule
